// File: hdl/gmvn_pkg.sv
// shared types and constants for the grid mesh vertex normal block
package gmvn_pkg;

   localparam int VEC_W  = 52;
   localparam int SUM_W  = 18;
   localparam int NORM_W = 16;
   localparam int IDX_W  = 15;

   // configuration register indexes (address bit 2)
   localparam logic REG_COLUMNS = 1'b0;
   localparam logic REG_ROWS    = 1'b1;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
   } req_type;

   typedef struct packed {
      logic        [IDX_W-1:0]  vertex_index;
      logic signed [23:0]       out_x;
      logic signed [23:0]       out_y;
      logic signed [23:0]       out_z;
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
      logic                     run_end;
      logic                     grid_done;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
   } pos_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] x;
      logic signed [SUM_W-1:0] y;
      logic signed [SUM_W-1:0] z;
   } sum_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] x;
      logic signed [NORM_W-1:0] y;
      logic signed [NORM_W-1:0] z;
   } norm_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
   } vec_type;

endpackage

// File: hdl/gmvn_unit.sv
// iterative unit vector unit: normalize, sum of squares, bit-serial root and divide
module gmvn_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  gmvn_pkg::vec_type  vec_in,
   output logic               done,
   output gmvn_pkg::norm_type norm_out
);
   import gmvn_pkg::*;

   localparam logic [2:0] U_IDLE  = 3'd0;
   localparam logic [2:0] U_NORM  = 3'd1;
   localparam logic [2:0] U_SQ    = 3'd2;
   localparam logic [2:0] U_SQRT  = 3'd3;
   localparam logic [2:0] U_DLOAD = 3'd4;
   localparam logic [2:0] U_DIV   = 3'd5;
   localparam logic [2:0] U_DONE  = 3'd6;

   logic [2:0]             state_ff;
   logic [VEC_W-1:0]       m_ff [3];
   logic [2:0]             neg_ff;
   logic [61:0]            s_ff;
   logic [59:0]            sq_ff;
   logic [32:0]            rem_ff;
   logic [30:0]            root_ff;
   logic [30:0]            drem_ff;
   logic [14:0]            nb_ff;
   logic [14:0]            q_ff;
   logic [4:0]             cnt_ff;
   logic [1:0]             comp_ff;
   logic signed [NORM_W-1:0] res_ff [3];

   logic [VEC_W-1:0] top;
   logic [1:0]       sq_sel;
   logic [34:0]      rem_in;
   logic [34:0]      trial;
   logic [44:0]      num;
   logic [31:0]      drem_in;
   logic             qbit;
   logic [14:0]      qn;

   always_comb begin
      top = m_ff[0];
      if (m_ff[1] > top) top = m_ff[1];
      if (m_ff[2] > top) top = m_ff[2];
      sq_sel  = (cnt_ff >= 5'd3) ? 2'd2 : cnt_ff[1:0];
      rem_in  = {rem_ff, s_ff[61:60]};
      trial   = {2'b00, root_ff, 2'b01};
      num     = {1'b0, m_ff[comp_ff][29:0], 14'b0} + 45'(root_ff[30:1]);
      drem_in = {drem_ff, nb_ff[14]};
      qbit    = (drem_in >= {1'b0, root_ff});
      qn      = {q_ff[13:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         cnt_ff   <= '0;
         comp_ff  <= '0;
      end else begin
         unique case (state_ff)
            U_IDLE: begin
               if (start) begin
                  neg_ff   <= {vec_in.z < 0, vec_in.y < 0, vec_in.x < 0};
                  m_ff[0]  <= (vec_in.x < 0) ? VEC_W'(-vec_in.x) : VEC_W'(vec_in.x);
                  m_ff[1]  <= (vec_in.y < 0) ? VEC_W'(-vec_in.y) : VEC_W'(vec_in.y);
                  m_ff[2]  <= (vec_in.z < 0) ? VEC_W'(-vec_in.z) : VEC_W'(vec_in.z);
                  state_ff <= U_NORM;
               end
            end
            U_NORM: begin
               priority if (top == '0) begin
                  res_ff[0] <= '0;
                  res_ff[1] <= '0;
                  res_ff[2] <= '0;
                  state_ff  <= U_DONE;
               end else if (top < (VEC_W'(1) << 21)) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 8;
               end else if (top < (VEC_W'(1) << 29)) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
               end else if (top >= (VEC_W'(1) << 38)) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 8;
               end else if (top >= (VEC_W'(1) << 30)) begin
                  for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
               end else begin
                  s_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= U_SQ;
               end
            end
            U_SQ: begin
               // one square per cycle, registered in sq_ff before it is accumulated
               if (cnt_ff < 5'd3) sq_ff <= m_ff[sq_sel][29:0] * m_ff[sq_sel][29:0];
               if (cnt_ff >= 5'd1) s_ff <= s_ff + 62'(sq_ff);
               if (cnt_ff == 5'd3) begin
                  cnt_ff   <= '0;
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  state_ff <= U_SQRT;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            U_SQRT: begin
               s_ff <= s_ff << 2;
               if (rem_in >= trial) begin
                  rem_ff  <= 33'(rem_in - trial);
                  root_ff <= {root_ff[29:0], 1'b1};
               end else begin
                  rem_ff  <= 33'(rem_in);
                  root_ff <= {root_ff[29:0], 1'b0};
               end
               if (cnt_ff == 5'd30) begin
                  comp_ff  <= '0;
                  state_ff <= U_DLOAD;
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            U_DLOAD: begin
               // quotient fits 15 bits, so the top of the numerator is below the root
               drem_ff  <= {1'b0, num[44:15]};
               nb_ff    <= num[14:0];
               q_ff     <= '0;
               cnt_ff   <= '0;
               state_ff <= U_DIV;
            end
            U_DIV: begin
               nb_ff   <= nb_ff << 1;
               drem_ff <= qbit ? 31'(drem_in - {1'b0, root_ff}) : 31'(drem_in);
               q_ff    <= qn;
               if (cnt_ff == 5'd14) begin
                  res_ff[comp_ff] <= neg_ff[comp_ff] ? -NORM_W'(qn) : NORM_W'(qn);
                  if (comp_ff == 2'd2) begin
                     state_ff <= U_DONE;
                  end else begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= U_DLOAD;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 5'd1;
               end
            end
            U_DONE: begin
               state_ff <= U_IDLE;
            end
            default: begin
               state_ff <= U_IDLE;
            end
         endcase
      end
   end

   assign done       = (state_ff == U_DONE);
   assign norm_out.x = res_ff[0];
   assign norm_out.y = res_ff[1];
   assign norm_out.z = res_ff[2];

endmodule

// File: hdl/grid_mesh_vertex_normals_core.sv
// top level: column stores, quad sequencer, cross products and result register
// Particles enter column by column (row fastest) as Q12.12 positions; each vertex leaves
// with its index, position and Q1.14 unit normal once its last quad is done, up to four
// per particle, the last one flagged run_end and the grid's final vertex grid_done.
// A particle on the first column or first row passes straight to the end state; any other
// takes longer (less when a normal has zero length, more while rsp_stall holds a
// result): two face normals and up to four vertex normals all go through one
// shared unit-vector unit whose square root and three 15-bit divides run one bit
// per cycle, plus a 25x25 multiplier for the cross products, 6 products per face.
// req_stall is high for the whole item. A write to either register restarts the
// grid at column 0, row 0.
module grid_mesh_vertex_normals_core #(
   parameter int MAX_ROWS    = 32,
   parameter int MAX_COLUMNS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gmvn_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gmvn_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import gmvn_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLUMNS);
   localparam int DEPTH = 2 * (2 ** RW);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RD     = 4'd1;
   localparam logic [3:0] S_MUL    = 4'd2;
   localparam logic [3:0] S_FSTART = 4'd3;
   localparam logic [3:0] S_FWAIT  = 4'd4;
   localparam logic [3:0] S_ADD    = 4'd5;
   localparam logic [3:0] S_WB     = 4'd6;
   localparam logic [3:0] S_ESTART = 4'd7;
   localparam logic [3:0] S_EWAIT  = 4'd8;
   localparam logic [3:0] S_EOUT   = 4'd9;
   localparam logic [3:0] S_FIN    = 4'd10;

   logic [3:0]    state_ff;
   logic [10:0]   cols_ff;
   logic [5:0]    rows_ff;
   logic [RW-1:0] row_ff;
   logic [CW-1:0] col_ff;
   logic          bank_ff;
   logic          lastcol_ff;
   logic          lastrow_ff;
   logic [2:0]    cnt_ff;
   logic          face_ff;
   logic [IDX_W-1:0] base_ff;
   pos_type       p_ff [4];
   sum_type       s_ff [4];
   norm_type      n1_ff;
   norm_type      n2_ff;
   logic signed [VEC_W-1:0] x_ff [3];
   logic signed [49:0]      prod_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   pos_type pos_mem [DEPTH];
   sum_type sum_mem [DEPTH];
   pos_type rd_pos_ff;
   sum_type rd_sum_ff;

   logic [31:0]   cols_eff;
   logic [31:0]   rows_eff;
   logic          accept;
   logic          cfg_wr;
   logic          last_col;
   logic          last_row;
   logic [RW:0]   slot_addr;
   logic [RW:0]   wr_addr;
   logic          sum_wr;
   sum_type       sum_wdata;
   logic [3:0]    emit_en;
   logic [3:0]    higher;
   pos_type       pa;
   pos_type       pb;
   pos_type       pc;
   logic signed [24:0] ux, uy, uz, wx, wy, wz;
   logic signed [24:0] op_a, op_b;
   logic [2:0]    acc_k;
   logic          unit_start;
   vec_type       unit_vec;
   logic          unit_done;
   norm_type      unit_norm;
   logic [31:0]   vidx;

   always_comb begin
      priority if (cols_ff < 11'd2) cols_eff = 32'd2;
      else if (32'(cols_ff) > MAX_COLUMNS) cols_eff = 32'(MAX_COLUMNS);
      else cols_eff = 32'(cols_ff);
      priority if (rows_ff < 6'd2) rows_eff = 32'd2;
      else if (32'(rows_ff) > MAX_ROWS) rows_eff = 32'(MAX_ROWS);
      else rows_eff = 32'(rows_ff);
   end

   assign accept   = (state_ff == S_IDLE) && req_valid;
   assign cfg_wr   = csr_psel && csr_penable && csr_pwrite;
   assign last_col = (32'(col_ff) == cols_eff - 32'd1);
   assign last_row = (32'(row_ff) == rows_eff - 32'd1);

   // slot 0 prev[r-1], slot 1 cur[r-1], slot 2 prev[r], slot 3 cur[r]
   assign slot_addr = {cnt_ff[0] ? bank_ff : ~bank_ff,
                       cnt_ff[1] ? row_ff : row_ff - 1'b1};

   assign emit_en = {lastcol_ff && lastrow_ff, lastrow_ff, lastcol_ff, 1'b1};
   assign higher  = emit_en & (4'b1110 << cnt_ff[1:0]);

   // column stores
   assign wr_addr   = accept ? {bank_ff, row_ff} : slot_addr;
   assign sum_wr    = accept || (state_ff == S_WB);
   assign sum_wdata = accept ? sum_type'('0) : s_ff[cnt_ff[1:0]];

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_mem[wr_addr] <= pos_type'(req_data);
      end
      if (sum_wr) begin
         sum_mem[wr_addr] <= sum_wdata;
      end
      rd_pos_ff <= pos_mem[slot_addr];
      rd_sum_ff <= sum_mem[slot_addr];
   end

   // cross product operands
   always_comb begin
      pa = face_ff ? p_ff[2] : p_ff[0];
      pb = p_ff[1];
      pc = face_ff ? p_ff[3] : p_ff[2];
      ux = 25'(pb.x) - 25'(pa.x);
      uy = 25'(pb.y) - 25'(pa.y);
      uz = 25'(pb.z) - 25'(pa.z);
      wx = 25'(pc.x) - 25'(pa.x);
      wy = 25'(pc.y) - 25'(pa.y);
      wz = 25'(pc.z) - 25'(pa.z);
      unique case (cnt_ff)
         3'd0: begin op_a = uy; op_b = wz; end
         3'd1: begin op_a = uz; op_b = wy; end
         3'd2: begin op_a = uz; op_b = wx; end
         3'd3: begin op_a = ux; op_b = wz; end
         3'd4: begin op_a = ux; op_b = wy; end
         3'd5: begin op_a = uy; op_b = wx; end
         default: begin op_a = ux; op_b = wx; end
      endcase
      acc_k = cnt_ff - 3'd1;
   end

   assign unit_start = (state_ff == S_FSTART) ||
                       ((state_ff == S_ESTART) && emit_en[cnt_ff[1:0]]);

   always_comb begin
      if (state_ff == S_FSTART) begin
         unit_vec.x = x_ff[0];
         unit_vec.y = x_ff[1];
         unit_vec.z = x_ff[2];
      end else begin
         unit_vec.x = VEC_W'(s_ff[cnt_ff[1:0]].x);
         unit_vec.y = VEC_W'(s_ff[cnt_ff[1:0]].y);
         unit_vec.z = VEC_W'(s_ff[cnt_ff[1:0]].z);
      end
   end

   gmvn_unit u_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .vec_in   (unit_vec),
      .done     (unit_done),
      .norm_out (unit_norm)
   );

   assign vidx = 32'(base_ff) + (cnt_ff[0] ? rows_eff : 32'd0)
               + (cnt_ff[1] ? 32'(row_ff) : 32'(row_ff) - 32'd1);

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         p_ff[3]   <= pos_type'(req_data);
         s_ff[3]   <= '0;
         base_ff   <= IDX_W'((32'(col_ff) - 32'd1) * rows_eff);
      end
      if (state_ff == S_RD && cnt_ff != 3'd0) begin
         p_ff[2'(acc_k)] <= rd_pos_ff;
         s_ff[2'(acc_k)] <= rd_sum_ff;
      end
      if (state_ff == S_MUL) begin
         if (cnt_ff < 3'd6) prod_ff <= op_a * op_b;
         if (cnt_ff != 3'd0) begin
            if (!acc_k[0]) x_ff[acc_k[2:1]] <= VEC_W'(prod_ff);
            else x_ff[acc_k[2:1]] <= x_ff[acc_k[2:1]] - VEC_W'(prod_ff);
         end
      end
      if (state_ff == S_FWAIT && unit_done) begin
         if (face_ff) n2_ff <= unit_norm;
         else n1_ff <= unit_norm;
      end
      if (state_ff == S_ADD) begin
         s_ff[0].x <= s_ff[0].x + SUM_W'(n1_ff.x);
         s_ff[0].y <= s_ff[0].y + SUM_W'(n1_ff.y);
         s_ff[0].z <= s_ff[0].z + SUM_W'(n1_ff.z);
         s_ff[1].x <= s_ff[1].x + SUM_W'(n1_ff.x) + SUM_W'(n2_ff.x);
         s_ff[1].y <= s_ff[1].y + SUM_W'(n1_ff.y) + SUM_W'(n2_ff.y);
         s_ff[1].z <= s_ff[1].z + SUM_W'(n1_ff.z) + SUM_W'(n2_ff.z);
         s_ff[2].x <= s_ff[2].x + SUM_W'(n1_ff.x) + SUM_W'(n2_ff.x);
         s_ff[2].y <= s_ff[2].y + SUM_W'(n1_ff.y) + SUM_W'(n2_ff.y);
         s_ff[2].z <= s_ff[2].z + SUM_W'(n1_ff.z) + SUM_W'(n2_ff.z);
         s_ff[3].x <= SUM_W'(n2_ff.x);
         s_ff[3].y <= SUM_W'(n2_ff.y);
         s_ff[3].z <= SUM_W'(n2_ff.z);
      end
      if (state_ff == S_EWAIT && unit_done) begin
         rsp_data_ff.vertex_index <= IDX_W'(vidx);
         rsp_data_ff.out_x        <= p_ff[cnt_ff[1:0]].x;
         rsp_data_ff.out_y        <= p_ff[cnt_ff[1:0]].y;
         rsp_data_ff.out_z        <= p_ff[cnt_ff[1:0]].z;
         rsp_data_ff.normal_x     <= unit_norm.x;
         rsp_data_ff.normal_y     <= unit_norm.y;
         rsp_data_ff.normal_z     <= unit_norm.z;
         rsp_data_ff.run_end      <= (higher == 4'b0000);
         rsp_data_ff.grid_done    <= (cnt_ff[1:0] == 2'd3);
      end
   end

   // sequencer, counters and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cols_ff      <= 11'd10;
         rows_ff      <= 6'd10;
         row_ff       <= '0;
         col_ff       <= '0;
         bank_ff      <= 1'b0;
         cnt_ff       <= '0;
         face_ff      <= 1'b0;
         lastcol_ff   <= 1'b0;
         lastrow_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            if (csr_paddr[2] == REG_ROWS) rows_ff <= csr_pwdata[5:0];
            else cols_ff <= csr_pwdata[10:0];
            row_ff <= '0;
            col_ff <= '0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  lastcol_ff <= last_col;
                  lastrow_ff <= last_row;
                  cnt_ff     <= '0;
                  state_ff   <= ((col_ff != '0) && (row_ff != '0)) ? S_RD : S_FIN;
               end
            end
            S_RD: begin
               if (cnt_ff == 3'd3) begin
                  cnt_ff   <= '0;
                  face_ff  <= 1'b0;
                  state_ff <= S_MUL;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_MUL: begin
               if (cnt_ff == 3'd6) state_ff <= S_FSTART;
               else cnt_ff <= cnt_ff + 3'd1;
            end
            S_FSTART: begin
               state_ff <= S_FWAIT;
            end
            S_FWAIT: begin
               if (unit_done) begin
                  cnt_ff <= '0;
                  if (face_ff) begin
                     state_ff <= S_ADD;
                  end else begin
                     face_ff  <= 1'b1;
                     state_ff <= S_MUL;
                  end
               end
            end
            S_ADD: begin
               cnt_ff   <= '0;
               state_ff <= S_WB;
            end
            S_WB: begin
               if (cnt_ff == 3'd3) begin
                  cnt_ff   <= '0;
                  state_ff <= S_ESTART;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_ESTART: begin
               priority if (emit_en[cnt_ff[1:0]]) state_ff <= S_EWAIT;
               else if (cnt_ff == 3'd3) state_ff <= S_FIN;
               else cnt_ff <= cnt_ff + 3'd1;
            end
            S_EWAIT: begin
               if (unit_done) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_EOUT;
               end
            end
            S_EOUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (cnt_ff == 3'd3) begin
                     state_ff <= S_FIN;
                  end else begin
                     cnt_ff   <= cnt_ff + 3'd1;
                     state_ff <= S_ESTART;
                  end
               end
            end
            S_FIN: begin
               // column end swaps the store banks
               if (!lastrow_ff) begin
                  row_ff <= row_ff + 1'b1;
               end else begin
                  row_ff  <= '0;
                  bank_ff <= ~bank_ff;
                  col_ff  <= lastcol_ff ? '0 : col_ff + 1'b1;
               end
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_ROWS) ? {26'b0, rows_ff} : {21'b0, cols_ff};

endmodule
